### design/sps_pkg.sv
// Shared types, constants and coil tables for the stepper phase sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sps_pkg;

   // transaction opcodes
   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_MOVE    = 2'd1,
      ACT_ROTATE  = 2'd2,
      ACT_RELEASE = 2'd3
   } action_type;

   // drive mode codes (code 3 steps like full-step two-phase)
   localparam logic [1:0] MODE_FULL = 2'd0;
   localparam logic [1:0] MODE_HALF = 2'd1;
   localparam logic [1:0] MODE_WAVE = 2'd2;

   // field widths
   localparam int COUNT_W = 24;
   localparam int ANGLE_W = 16;
   localparam int DELAY_W = 16;
   localparam int POS_W   = 32;

   // angle * steps-per-turn stays at or below 2^27 over the parameter range
   localparam int PROD_W  = 28;
   localparam int TURN_W  = 13;

   // x / 360 == (x >> 3) / 45; exact reciprocal of 45 for a 25-bit dividend
   localparam int          RECIP_SHIFT = 31;
   localparam logic [25:0] RECIP_45    = 26'd47721859;
   localparam int          QUOT_W      = 19;

   // normalized command handed from the prep pipeline to the execute stage
   typedef struct packed {
      action_type           action;
      logic [COUNT_W-1:0]   mag;
      logic                 backward;
      logic [DELAY_W-1:0]   delay;
   } cmd_type;

   // coil pattern for a phase index, bits A1,A2,B1,B2 in 0..3
   function automatic logic [3:0] phase_coils(input logic [1:0] mode,
                                              input logic [2:0] phase);
      logic [3:0] pat;
      case (mode)
         MODE_HALF: begin
            case (phase)
               3'd0:    pat = 4'b0001;
               3'd1:    pat = 4'b0011;
               3'd2:    pat = 4'b0010;
               3'd3:    pat = 4'b0110;
               3'd4:    pat = 4'b0100;
               3'd5:    pat = 4'b1100;
               3'd6:    pat = 4'b1000;
               default: pat = 4'b1001;
            endcase
         end
         MODE_WAVE: begin
            case (phase[1:0])
               2'd0:    pat = 4'b0001;
               2'd1:    pat = 4'b0010;
               2'd2:    pat = 4'b0100;
               default: pat = 4'b1000;
            endcase
         end
         default: begin
            case (phase[1:0])
               2'd0:    pat = 4'b0011;
               2'd1:    pat = 4'b0110;
               2'd2:    pat = 4'b1100;
               default: pat = 4'b1001;
            endcase
         end
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

### design/sps_phase_step.sv
// Next phase index and coil pattern for one step in either direction.
// Depends on sps_pkg for mode codes and the coil tables.
`timescale 1ns / 1ps
`default_nettype none

module sps_phase_step
   import sps_pkg::*;
(
   input  wire logic [1:0] mode,
   input  wire logic [2:0] phase,
   input  wire logic       backward,
   output      logic [2:0] phase_next,
   output      logic [3:0] coil_next
);

   // half step wraps modulo 8, the others modulo 4
   always_comb begin
      if (mode == MODE_HALF) begin
         phase_next = backward ? (phase - 3'd1) : (phase + 3'd1);
      end else begin
         phase_next = {1'b0, (backward ? (phase[1:0] - 2'd1) : (phase[1:0] + 2'd1))};
      end
      coil_next = phase_coils(mode, phase_next);
   end

endmodule

`default_nettype wire

### design/sps_cmd_prep.sv
// Two-stage command prep: scales rotate angles to steps and takes magnitudes.
// Depends on sps_pkg; feeds the execute stage in the top level.
`timescale 1ns / 1ps
`default_nettype none

module sps_cmd_prep
   import sps_pkg::*;
#(
   parameter int STEPS_PER_TURN = 200
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [1:0]                drive_mode,
   input  wire logic                      in_valid,
   output      logic                      in_ready,
   input  wire action_type                in_action,
   input  wire logic signed [COUNT_W-1:0] in_count,
   input  wire logic signed [ANGLE_W-1:0] in_angle,
   input  wire logic [DELAY_W-1:0]        in_delay,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      cmd_type                   out_cmd
);

   localparam logic [TURN_W-1:0] TURN = TURN_W'(STEPS_PER_TURN);

   // stage a: operands plus |angle| * steps per turn
   logic                      a_valid_ff;
   action_type                a_action_ff;
   logic signed [COUNT_W-1:0] a_count_ff;
   logic                      a_neg_ff;
   logic [PROD_W-1:0]         a_prod_ff;
   logic [DELAY_W-1:0]        a_delay_ff;

   // stage b: normalized command
   logic    b_valid_ff;
   cmd_type b_cmd_ff;

   logic                      a_load;
   logic                      b_load;
   logic [ANGLE_W:0]          angle_ext;
   logic [ANGLE_W:0]          angle_mag;
   logic [ANGLE_W+TURN_W-1:0] angle_prod;
   logic [50:0]               quot_full;
   logic [QUOT_W-1:0]         quot;
   logic [COUNT_W-1:0]        rot_mag;
   logic [COUNT_W-1:0]        move_mag;
   cmd_type                   b_cmd_in;

   // pipeline flow control
   assign b_load   = a_valid_ff && (!b_valid_ff || out_ready);
   assign a_load   = in_valid && in_ready;
   assign in_ready = !a_valid_ff || b_load;

   // angle magnitude and scale
   always_comb begin
      angle_ext  = {in_angle[ANGLE_W-1], in_angle};
      angle_mag  = in_angle[ANGLE_W-1] ? ((ANGLE_W+1)'(0) - angle_ext) : angle_ext;
      angle_prod = (ANGLE_W+TURN_W)'(angle_mag) * (ANGLE_W+TURN_W)'(TURN);
   end

   // divide by 360 via shift by 3 and reciprocal of 45, then normalize
   always_comb begin
      quot_full = 51'(a_prod_ff[PROD_W-1:3]) * 51'(RECIP_45);
      quot      = quot_full[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      if (drive_mode == MODE_HALF) begin
         rot_mag = COUNT_W'({quot, 1'b0});
      end else begin
         rot_mag = COUNT_W'(quot);
      end
      move_mag = a_count_ff[COUNT_W-1] ? (COUNT_W'(0) - a_count_ff) : a_count_ff;

      b_cmd_in.action = a_action_ff;
      b_cmd_in.delay  = a_delay_ff;
      if (a_action_ff == ACT_ROTATE) begin
         b_cmd_in.mag      = rot_mag;
         b_cmd_in.backward = a_neg_ff;
      end else begin
         b_cmd_in.mag      = move_mag;
         b_cmd_in.backward = a_count_ff[COUNT_W-1];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            a_valid_ff <= in_valid;
         end
         if (!b_valid_ff || out_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_action_ff <= in_action;
         a_count_ff  <= in_count;
         a_neg_ff    <= in_angle[ANGLE_W-1];
         a_prod_ff   <= angle_prod[PROD_W-1:0];
         a_delay_ff  <= in_delay;
      end
      if (b_load) begin
         b_cmd_ff <= b_cmd_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_cmd   = b_cmd_ff;

endmodule

`default_nettype wire

### design/stepper_phase_sequencer_core.sv
// Stepper phase sequencer top level: command prep, step state and result register.
// Depends on sps_pkg, sps_cmd_prep and sps_phase_step.
//
//   port group  | direction | handshake            | contents
//   req_*       | in        | req_valid/req_ready  | action, step count, angle, delay
//   rsp_*       | out       | rsp_valid/rsp_ready  | coils, position, busy, stepped, rejected
//   csr_*       | in        | csr_wr_en            | drive mode
//
// One transaction per cycle sustained while the result is not stalled; an accepted
// transaction passes angle scaling, reciprocal divide by 360, then the step state
// update that loads the result register.
// Synchronous active-high reset clears all control state; coils off, position 0.
// A stalled result holds the pipeline; up to three transactions stay in flight.
`timescale 1ns / 1ps
`default_nettype none

module stepper_phase_sequencer_core
   import sps_pkg::*;
#(
   parameter int STEPS_PER_TURN = 200
)(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire logic [1:0]                req_action,
   input  wire logic signed [COUNT_W-1:0] req_step_count,
   input  wire logic signed [ANGLE_W-1:0] req_angle_degrees,
   input  wire logic [DELAY_W-1:0]        req_step_delay_ms,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output      logic [3:0]                rsp_coils,
   output      logic signed [POS_W-1:0]   rsp_position,
   output      logic                      rsp_busy_res,
   output      logic                      rsp_stepped,
   output      logic                      rsp_rejected,
   input  wire logic                      csr_wr_en,
   input  wire logic [1:0]                csr_wr_data
);

   // step state
   logic [1:0]         drive_mode_ff;
   logic [2:0]         phase_ff,    phase_in;
   logic [POS_W-1:0]   pos_ff,      pos_in;
   logic [COUNT_W-1:0] steps_ff,    steps_in;
   logic               back_ff,     back_in;
   logic [DELAY_W-1:0] wait_ff,     wait_in;
   logic [DELAY_W-1:0] reload_ff,   reload_in;
   logic               moving_ff,   moving_in;
   logic [3:0]         coil_ff,     coil_in;

   // result register
   logic               rsp_valid_ff;
   logic [3:0]         rsp_coils_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic               rsp_busy_ff;
   logic               rsp_stepped_ff, stepped_in;
   logic               rsp_rejected_ff, rejected_in;

   logic               cmd_valid;
   logic               cmd_ready;
   cmd_type            cmd;
   logic               exec_fire;
   logic               do_step;
   logic               step_dir;
   logic [DELAY_W-1:0] wait_dec;
   logic [2:0]         step_phase;
   logic [3:0]         step_coil;

   sps_cmd_prep #(
      .STEPS_PER_TURN(STEPS_PER_TURN)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .drive_mode (drive_mode_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_action  (action_type'(req_action)),
      .in_count   (req_step_count),
      .in_angle   (req_angle_degrees),
      .in_delay   (req_step_delay_ms),
      .out_valid  (cmd_valid),
      .out_ready  (cmd_ready),
      .out_cmd    (cmd)
   );

   sps_phase_step u_step (
      .mode       (drive_mode_ff),
      .phase      (phase_ff),
      .backward   (step_dir),
      .phase_next (step_phase),
      .coil_next  (step_coil)
   );

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign exec_fire = cmd_valid && cmd_ready;
   assign wait_dec  = (wait_ff != '0) ? (wait_ff - DELAY_W'(1)) : wait_ff;

   // command decode and step state update
   always_comb begin
      steps_in    = steps_ff;
      back_in     = back_ff;
      wait_in     = wait_ff;
      reload_in   = reload_ff;
      moving_in   = moving_ff;
      coil_in     = coil_ff;
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      do_step     = 1'b0;
      step_dir    = back_ff;
      stepped_in  = 1'b0;
      rejected_in = 1'b0;

      unique case (cmd.action)
         ACT_TICK: begin
            if (moving_ff) begin
               wait_in = wait_dec;
               if (wait_dec == '0) begin
                  if (steps_ff != '0) begin
                     do_step   = 1'b1;
                     steps_in  = steps_ff - COUNT_W'(1);
                     wait_in   = reload_ff;
                     moving_in = !(steps_ff == COUNT_W'(1) && reload_ff == '0);
                  end else begin
                     moving_in = 1'b0;
                  end
               end
            end
         end
         ACT_MOVE, ACT_ROTATE: begin
            if (moving_ff) begin
               rejected_in = 1'b1;
            end else if (cmd.mag != '0) begin
               do_step   = 1'b1;
               step_dir  = cmd.backward;
               back_in   = cmd.backward;
               reload_in = cmd.delay;
               steps_in  = cmd.mag - COUNT_W'(1);
               wait_in   = cmd.delay;
               moving_in = (cmd.mag != COUNT_W'(1)) || (cmd.delay != '0);
            end
         end
         ACT_RELEASE: begin
            if (moving_ff) begin
               rejected_in = 1'b1;
            end else begin
               coil_in = 4'b0000;
            end
         end
         default: begin
         end
      endcase

      // one step of the phase sequence
      if (do_step) begin
         phase_in   = step_phase;
         coil_in    = step_coil;
         pos_in     = step_dir ? (pos_ff - POS_W'(1)) : (pos_ff + POS_W'(1));
         stepped_in = 1'b1;
      end
   end

   // state registers; a mode write restarts the phase sequence
   always_ff @(posedge clock) begin
      if (reset) begin
         drive_mode_ff <= MODE_FULL;
         phase_ff      <= 3'd0;
         pos_ff        <= '0;
         steps_ff      <= '0;
         back_ff       <= 1'b0;
         wait_ff       <= '0;
         reload_ff     <= '0;
         moving_ff     <= 1'b0;
         coil_ff       <= 4'b0000;
      end else begin
         if (exec_fire) begin
            pos_ff    <= pos_in;
            steps_ff  <= steps_in;
            back_ff   <= back_in;
            wait_ff   <= wait_in;
            reload_ff <= reload_in;
            moving_ff <= moving_in;
            coil_ff   <= coil_in;
         end
         if (csr_wr_en) begin
            drive_mode_ff <= csr_wr_data;
            phase_ff      <= 3'd0;
         end else if (exec_fire) begin
            phase_ff      <= phase_in;
         end
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_ready) begin
         rsp_valid_ff <= cmd_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_coils_ff    <= coil_in;
         rsp_pos_ff      <= pos_in;
         rsp_busy_ff     <= moving_in;
         rsp_stepped_ff  <= stepped_in;
         rsp_rejected_ff <= rejected_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_coils    = rsp_coils_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_busy_res = rsp_busy_ff;
   assign rsp_stepped  = rsp_stepped_ff;
   assign rsp_rejected = rsp_rejected_ff;

   // a rejected command never steps
   a_reject_no_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_rejected_ff && rsp_stepped_ff))
      else $error("rejected transaction also stepped");

   // a step always drives a coil pattern
   a_step_drives_coils: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stepped_ff) |-> (rsp_coils_ff != 4'b0000))
      else $error("step taken with coils off");

   // idle means no steps pending
   a_idle_no_steps: assert property (@(posedge clock) disable iff (reset)
      !moving_ff |-> (steps_ff == '0))
      else $error("steps pending while idle");

   // result register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result valid after reset");

endmodule

`default_nettype wire
